### hw/rtl/u8san_pkg.sv
// Shared types, byte constants and decode helpers for the UTF-8 sanitizer.
// Used by the engine, the emitter and the top level; depends on nothing.
package u8san_pkg;

   localparam int COUNT_BITS_DEFAULT = 32;
   localparam int BURST_MAX = 6;
   localparam int BURST_CNT_BITS = 3;

   localparam logic [31:0] LIMIT_RESET = 32'hFFFF_FFFF;

   // Item kinds on the request side.
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END = 1'b1;

   localparam logic [7:0] ASCII_TOP = 8'h80;
   localparam logic [1:0] CONT_TAG = 2'b10;
   localparam logic [7:0] LEAD2_LO = 8'hC2;
   localparam logic [7:0] LEAD2_HI = 8'hDF;
   localparam logic [7:0] LEAD3_LO = 8'hE0;
   localparam logic [7:0] LEAD3_HI = 8'hEF;
   localparam logic [7:0] LEAD4_LO = 8'hF0;
   localparam logic [7:0] LEAD4_HI = 8'hF4;
   localparam logic [7:0] LEAD_SURR = 8'hED;
   localparam logic [7:0] SEC3_MIN = 8'hA0;
   localparam logic [7:0] SURR_MAX = 8'h9F;
   localparam logic [7:0] SEC4_MIN = 8'h90;
   localparam logic [7:0] SEC4_MAX = 8'h8F;

   // Replacement character, first byte in the lowest slot.
   localparam logic [2:0][7:0] REPL_SEQ = {8'hBD, 8'hBF, 8'hEF};
   localparam logic [2:0] REPL_LEN = 3'd3;

   typedef struct packed {
      logic [BURST_MAX-1:0][7:0] bytes;
      logic [BURST_CNT_BITS-1:0] count;
      logic                      end_mark;
      logic                      trunc;
   } burst_type;

   function automatic logic [2:0] lead_width(input logic [7:0] b);
      logic [2:0] w;
      w = 3'd0;
      if (b >= LEAD2_LO && b <= LEAD2_HI) w = 3'd2;
      else if (b >= LEAD3_LO && b <= LEAD3_HI) w = 3'd3;
      else if (b >= LEAD4_LO && b <= LEAD4_HI) w = 3'd4;
      return w;
   endfunction

   // Overlong, surrogate and out-of-range checks on the second byte.
   function automatic logic second_ok(input logic [2:0] w, input logic [7:0] lead,
                                      input logic [7:0] sec);
      logic ok;
      if (w == 3'd2) begin
         ok = 1'b1;
      end else if (w == 3'd3) begin
         ok = !(lead == LEAD3_LO && sec < SEC3_MIN) && !(lead == LEAD_SURR && sec > SURR_MAX);
      end else begin
         ok = !(lead == LEAD4_LO && sec < SEC4_MIN) && !(lead == LEAD4_HI && sec > SEC4_MAX);
      end
      return ok;
   endfunction

endpackage

### hw/rtl/u8san_engine.sv
// Decode engine: sequence state, byte-limit accounting and burst assembly.
// Depends on u8san_pkg.
module u8san_engine #(
   parameter int COUNT_BITS = u8san_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic                  item_kind,
   input  logic [7:0]            item_byte,
   input  logic                  csr_wr_en,
   input  logic [31:0]           csr_wr_data,
   output u8san_pkg::burst_type  burst
);

   localparam int LimW = (COUNT_BITS > 32) ? COUNT_BITS : 32;

   logic [31:0]           limit_ff;
   logic [2:0][7:0]       pend_bytes_ff, pend_bytes_in;
   logic [1:0]            pend_cnt_ff, pend_cnt_in;
   logic [2:0]            width_ff, width_in;
   logic [COUNT_BITS-1:0] kept_ff, kept_in;
   logic                  retain_ff, retain_in;

   logic [LimW-1:0]       lim_wide, cmax_wide, lim_cap;
   logic [COUNT_BITS-1:0] lim;
   logic                  pend, is_cont;
   logic [2:0]            lw;
   logic                  a_req, b_req, a_out, b_out, is_end;
   logic [2:0]            b_cnt;
   logic [3:0][7:0]       b_bytes;
   logic [COUNT_BITS:0]   sum_a, sum_b;
   logic [COUNT_BITS-1:0] kept_a;
   logic                  retain_a, fit_a, fit_b;
   logic [2:0]            off;

   // The limit in force never exceeds what the counter can hold.
   always_comb begin
      lim_wide = LimW'(limit_ff);
      cmax_wide = LimW'({COUNT_BITS{1'b1}});
      lim_cap = (lim_wide > cmax_wide) ? cmax_wide : lim_wide;
      lim = lim_cap[COUNT_BITS-1:0];
   end

   always_comb begin
      pend = (pend_cnt_ff != 2'd0) && (width_ff >= 3'd2) && (width_ff <= 3'd4);
      is_cont = (item_byte[7:6] == u8san_pkg::CONT_TAG);
      lw = u8san_pkg::lead_width(item_byte);
      is_end = (item_kind == u8san_pkg::KIND_END);

      a_req = 1'b0;
      b_req = 1'b0;
      b_cnt = 3'd0;
      b_bytes = '0;
      pend_bytes_in = pend_bytes_ff;
      pend_cnt_in = pend_cnt_ff;
      width_in = width_ff;

      if (is_end) begin
         a_req = (pend_cnt_ff != 2'd0);
         pend_cnt_in = 2'd0;
         width_in = 3'd0;
      end else if (pend && is_cont) begin
         if (({1'b0, pend_cnt_ff} + 3'd1) < width_ff) begin
            if (pend_cnt_ff == 2'd1) pend_bytes_in[1] = item_byte;
            else pend_bytes_in[2] = item_byte;
            if (pend_cnt_ff != 2'd3) pend_cnt_in = pend_cnt_ff + 2'd1;
         end else begin
            pend_cnt_in = 2'd0;
            width_in = 3'd0;
            b_req = 1'b1;
            if (u8san_pkg::second_ok(width_ff, pend_bytes_ff[0], pend_bytes_ff[1])) begin
               b_cnt = width_ff;
               b_bytes[0] = pend_bytes_ff[0];
               b_bytes[1] = (width_ff == 3'd2) ? item_byte : pend_bytes_ff[1];
               b_bytes[2] = (width_ff == 3'd3) ? item_byte : pend_bytes_ff[2];
               b_bytes[3] = item_byte;
            end else begin
               b_cnt = u8san_pkg::REPL_LEN;
               b_bytes = {8'h00, u8san_pkg::REPL_SEQ};
            end
         end
      end else begin
         // A broken sequence is replaced and this byte is read again as a lead.
         a_req = pend;
         pend_cnt_in = 2'd0;
         width_in = 3'd0;
         if (item_byte < u8san_pkg::ASCII_TOP) begin
            b_req = 1'b1;
            b_cnt = 3'd1;
            b_bytes[0] = item_byte;
         end else if (lw == 3'd0) begin
            b_req = 1'b1;
            b_cnt = u8san_pkg::REPL_LEN;
            b_bytes = {8'h00, u8san_pkg::REPL_SEQ};
         end else begin
            width_in = lw;
            pend_bytes_in[0] = item_byte;
            pend_cnt_in = 2'd1;
         end
      end
   end

   // Two units at most per item, each written whole or not at all.
   always_comb begin
      sum_a = {1'b0, kept_ff} + (COUNT_BITS+1)'(u8san_pkg::REPL_LEN);
      fit_a = retain_ff && (sum_a <= {1'b0, lim});
      a_out = a_req && fit_a;
      kept_a = a_out ? sum_a[COUNT_BITS-1:0] : kept_ff;
      retain_a = retain_ff && !(a_req && !fit_a);

      sum_b = {1'b0, kept_a} + (COUNT_BITS+1)'(b_cnt);
      fit_b = retain_a && (sum_b <= {1'b0, lim});
      b_out = b_req && fit_b;

      if (is_end) begin
         kept_in = '0;
         retain_in = 1'b1;
      end else begin
         kept_in = b_out ? sum_b[COUNT_BITS-1:0] : kept_a;
         retain_in = retain_a && !(b_req && !fit_b);
      end
   end

   always_comb begin
      off = a_out ? u8san_pkg::REPL_LEN : 3'd0;
      burst.bytes = '0;
      for (int i = 0; i < u8san_pkg::BURST_MAX; i++) begin
         int idx;
         idx = i - int'(off);
         if (a_out && i < 3) begin
            burst.bytes[i] = u8san_pkg::REPL_SEQ[2'(i)];
         end else if (b_out && idx >= 0 && idx < int'(b_cnt)) begin
            burst.bytes[i] = b_bytes[2'(idx)];
         end
      end
      burst.count = (a_out ? u8san_pkg::REPL_LEN : 3'd0) + (b_out ? b_cnt : 3'd0)
                    + {2'd0, is_end};
      burst.end_mark = is_end;
      burst.trunc = !retain_a;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= u8san_pkg::LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bytes_ff <= '0;
         pend_cnt_ff <= 2'd0;
         width_ff <= 3'd0;
         kept_ff <= '0;
         retain_ff <= 1'b1;
      end else if (take) begin
         pend_bytes_ff <= pend_bytes_in;
         pend_cnt_ff <= pend_cnt_in;
         width_ff <= width_in;
         kept_ff <= kept_in;
         retain_ff <= retain_in;
      end
   end

endmodule

### hw/rtl/u8san_emitter.sv
// Result register: holds one item's burst of bytes and sends one beat per cycle while rsp_tready is high.
// Depends on u8san_pkg.
module u8san_emitter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  u8san_pkg::burst_type burst,
   output logic                 free,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic [1:0]           rsp_tuser,
   output logic                 rsp_tlast
);

   logic [u8san_pkg::BURST_MAX-1:0][7:0]  bytes_ff;
   logic [u8san_pkg::BURST_CNT_BITS-1:0]  cnt_ff;
   logic                                  end_ff;
   logic                                  trunc_ff;
   logic                                  final_beat;

   assign final_beat = (cnt_ff == 3'd1);
   // A new burst may come in as the final beat of the current one leaves.
   assign free = (cnt_ff == 3'd0) || (final_beat && rsp_tready);

   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign rsp_tdata = bytes_ff[0];
   assign rsp_tlast = final_beat;
   assign rsp_tuser[0] = end_ff && final_beat;
   assign rsp_tuser[1] = trunc_ff && end_ff && final_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= burst.count;
      end else if (rsp_tvalid && rsp_tready) begin
         cnt_ff <= cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff <= burst.bytes;
         end_ff <= burst.end_mark;
         trunc_ff <= burst.trunc;
      end else if (rsp_tvalid && rsp_tready) begin
         bytes_ff <= {8'h00, bytes_ff[u8san_pkg::BURST_MAX-1:1]};
      end
   end

endmodule

### hw/rtl/utf8_sanitizer_core.sv
// Top level of the UTF-8 sanitizer: input register, decode engine, result emitter.
// Depends on u8san_pkg, u8san_engine and u8san_emitter.
//
//   channel  direction  fields
//   req_*    in         tdata = data_byte[7:0]; tuser = kind
//   rsp_*    out        tdata = out_byte[7:0]; tuser = end_marker, truncated; tlast = last
//   csr_*    in         csr_wr_data = output_limit[31:0]
//
// Items that yield at most one result beat stream at one per cycle while rsp_tready
// is high. An item that yields n beats (up to six) keeps the emitter busy until its
// last beat leaves, and the item behind it waits in the input register meanwhile. The
// first beat of an item is valid once it has passed the input and result registers.
// Reset is synchronous and clears all sequence state; the limit returns to all ones.
// A stall on rsp backs up through the emitter into the input register and req_tready.
module utf8_sanitizer_core #(
   parameter int COUNT_BITS = u8san_pkg::COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte[7:0]
   output logic [1:0]  rsp_tuser,   // [0] end_marker, [1] truncated
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic                 in_valid_ff;
   logic                 in_kind_ff;
   logic [7:0]           in_byte_ff;
   logic                 emit_free;
   logic                 take;
   u8san_pkg::burst_type burst;

   assign take = in_valid_ff && emit_free;
   assign req_tready = !in_valid_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (take) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   u8san_engine #(
      .COUNT_BITS (COUNT_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .item_kind   (in_kind_ff),
      .item_byte   (in_byte_ff),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .burst       (burst)
   );

   u8san_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .load       (take && (burst.count != 3'd0)),
      .burst      (burst),
      .free       (emit_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### hw/rtl/u8san_checker.sv
// Port-level checks for utf8_sanitizer_core, bound to the top level.
// Depends only on the top level's ports.
module u8san_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   // A stalled result beat keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
                                    && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // The end marker closes its item and carries no byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && (rsp_tdata == 8'h00))
      else $error("end marker without tlast or with data");

   // Truncation is reported on the end marker only.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("truncated flag on a data beat");

   // Nothing is left to send right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

endmodule

bind utf8_sanitizer_core u8san_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

### bench/utf8_sanitizer_core_test.sv
`timescale 1ns / 100ps
// Self-checking bench for utf8_sanitizer_core: directed and random byte streams,
// a scoreboard class that predicts every result beat. Depends on u8san_pkg and the RTL.
module utf8_sanitizer_core_test;

   localparam int CNT_BITS = u8san_pkg::COUNT_BITS_DEFAULT;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_ITEMS = 25;
   localparam int RANDOM_PHASES = 8;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_marker;
      logic       truncated;
      logic       last;
   } rsp_beat_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
   } req_item_type;

   class sanitizer_scoreboard_type;
      logic [31:0]     limit;
      logic [7:0]      held [3];
      int unsigned     held_cnt;
      int unsigned     seq_len;
      longint unsigned kept;
      bit              keeping;
      logic [7:0]      step_bytes[$];
      rsp_beat_type    due_beats[$];
      int unsigned     errors;
      int unsigned     reqs_seen;
      int unsigned     beats_checked;
      int unsigned     ends_seen;
      int unsigned     cut_streams;

      function new();
         limit = u8san_pkg::LIMIT_RESET;
         held_cnt = 0;
         seq_len = 0;
         kept = 0;
         keeping = 1'b1;
         errors = 0;
         reqs_seen = 0;
         beats_checked = 0;
         ends_seen = 0;
         cut_streams = 0;
      endfunction

      function void set_limit(logic [31:0] value);
         limit = value;
      endfunction

      function int unsigned outstanding();
         return due_beats.size();
      endfunction

      // A unit is kept whole or not at all; the first miss stops output for the stream.
      function void keep_unit(int unsigned n, logic [3:0][7:0] u);
         longint unsigned lim;
         longint unsigned room;
         longint unsigned cap;
         int unsigned i;
         if (!keeping) return;
         cap = ((64'd1 << (CNT_BITS - 1)) << 1) - 64'd1;
         lim = limit;
         if (lim > cap) lim = cap;
         room = (kept >= lim) ? 0 : lim - kept;
         if (n > room) begin
            keeping = 1'b0;
            return;
         end
         for (i = 0; i < n; i++) step_bytes.push_back(u[i]);
         kept = kept + n;
      endfunction

      function void keep_replacement();
         keep_unit(3, {8'h00, u8san_pkg::REPL_SEQ});
      endfunction

      function void start_sequence(logic [7:0] b);
         if (b < u8san_pkg::ASCII_TOP) begin
            keep_unit(1, {24'h0, b});
         end else if (b >= u8san_pkg::LEAD2_LO && b <= u8san_pkg::LEAD2_HI) begin
            seq_len = 2;
         end else if (b >= u8san_pkg::LEAD3_LO && b <= u8san_pkg::LEAD3_HI) begin
            seq_len = 3;
         end else if (b >= u8san_pkg::LEAD4_LO && b <= u8san_pkg::LEAD4_HI) begin
            seq_len = 4;
         end else begin
            keep_replacement();
         end
         if (seq_len != 0) begin
            held[0] = b;
            held_cnt = 1;
         end
      endfunction

      function void decode_byte(logic [7:0] b);
         logic [7:0] lead;
         logic [7:0] sec;
         bit bad;
         if (held_cnt == 0) begin
            start_sequence(b);
            return;
         end
         // A non-continuation byte ends the partial sequence and is looked at again.
         if (b[7:6] != u8san_pkg::CONT_TAG) begin
            keep_replacement();
            held_cnt = 0;
            seq_len = 0;
            start_sequence(b);
            return;
         end
         if (held_cnt + 1 < seq_len) begin
            held[held_cnt] = b;
            held_cnt++;
            return;
         end
         lead = held[0];
         sec = (seq_len == 2) ? b : held[1];
         bad = 1'b0;
         if (seq_len == 3)
            bad = (lead == u8san_pkg::LEAD3_LO && sec < u8san_pkg::SEC3_MIN)
                  || (lead == u8san_pkg::LEAD_SURR && sec > u8san_pkg::SURR_MAX);
         else if (seq_len == 4)
            bad = (lead == u8san_pkg::LEAD4_LO && sec < u8san_pkg::SEC4_MIN)
                  || (lead == u8san_pkg::LEAD4_HI && sec > u8san_pkg::SEC4_MAX);
         if (bad)
            keep_replacement();
         else
            keep_unit(seq_len, {b, (seq_len == 3) ? b : held[2], sec, lead});
         held_cnt = 0;
         seq_len = 0;
      endfunction

      function void note_request(logic kind, logic [7:0] b);
         rsp_beat_type beat;
         int unsigned i;
         step_bytes.delete();
         reqs_seen++;
         if (kind == u8san_pkg::KIND_DATA) begin
            decode_byte(b);
            for (i = 0; i < step_bytes.size(); i++) begin
               beat = '{step_bytes[i], 1'b0, 1'b0, i + 1 == step_bytes.size()};
               due_beats.push_back(beat);
            end
         end else begin
            if (held_cnt != 0) keep_replacement();
            held_cnt = 0;
            seq_len = 0;
            for (i = 0; i < step_bytes.size(); i++) begin
               beat = '{step_bytes[i], 1'b0, 1'b0, 1'b0};
               due_beats.push_back(beat);
            end
            beat = '{8'h00, 1'b1, !keeping, 1'b1};
            due_beats.push_back(beat);
            ends_seen++;
            if (!keeping) cut_streams++;
            kept = 0;
            keeping = 1'b1;
         end
      endfunction

      function void check_response(logic [7:0] ob, logic em, logic tr, logic lst);
         rsp_beat_type want;
         if (due_beats.size() == 0) begin
            $error("result beat %h arrived with no expectation waiting", ob);
            errors++;
            return;
         end
         want = due_beats.pop_front();
         beats_checked++;
         if (ob !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, ob);
            errors++;
         end
         if (em !== want.end_marker) begin
            $error("end_marker: expected %b, got %b", want.end_marker, em);
            errors++;
         end
         if (tr !== want.truncated) begin
            $error("truncated: expected %b, got %b", want.truncated, tr);
            errors++;
         end
         if (lst !== want.last) begin
            $error("last: expected %b, got %b", want.last, lst);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // data_byte[7:0]
   logic        req_tuser = u8san_pkg::KIND_DATA;   // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;   // out_byte[7:0]
   logic [1:0]  rsp_tuser;   // [0] end_marker, [1] truncated
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = 32'h0;

   sanitizer_scoreboard_type sb;
   req_item_type plan[$];
   int unsigned burst_left = 0;
   int unsigned limit_writes = 0;
   int unsigned quiet = 0;
   int unsigned win_left = 0;
   int unsigned ready_mode = 0;
   logic [7:0]  ready_mask = 8'hFF;

   utf8_sanitizer_core #(.COUNT_BITS(CNT_BITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // The receiver switches between always ready, a rotating mask and coin flips.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata, rsp_tuser[0], rsp_tuser[1], rsp_tlast);
         if (win_left == 0) begin
            win_left = $urandom_range(16, 64);
            ready_mode = $urandom_range(0, 3);
            ready_mask = 8'($urandom_range(1, 255));
         end
         win_left--;
         ready_mask = {ready_mask[6:0], ready_mask[7]};
         case (ready_mode)
            0, 1: rsp_tready <= 1'b1;
            2: rsp_tready <= ready_mask[0];
            default: rsp_tready <= ($urandom_range(0, 2) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet <= 0;
         else
            quiet <= quiet + 1;
         if (quiet >= QUIET_LIMIT) begin
            $display("no beat moved for %0d cycles", QUIET_LIMIT);
            $display("utf8_sanitizer_core_test failed");
            $finish;
         end
      end
   end

   function void add_data(logic [7:0] b);
      plan.push_back('{u8san_pkg::KIND_DATA, b});
   endfunction

   function void add_end();
      plan.push_back('{u8san_pkg::KIND_END, 8'($urandom)});
   endfunction

   function logic [7:0] cont_byte();
      return 8'($urandom_range(8'h80, 8'hBF));
   endfunction

   // Mostly well-formed sequences with random content, plus noise, cut-off sequences and end markers.
   function void build_random_plan(int unsigned n);
      int unsigned pick;
      int unsigned k;
      logic [7:0] lead;
      logic [7:0] sec;
      while (plan.size() < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            add_data(8'($urandom_range(0, 127)));
         end else if (pick < 45) begin
            add_data(8'($urandom_range(u8san_pkg::LEAD2_LO, u8san_pkg::LEAD2_HI)));
            add_data(cont_byte());
         end else if (pick < 62) begin
            lead = 8'($urandom_range(u8san_pkg::LEAD3_LO, u8san_pkg::LEAD3_HI));
            if ($urandom_range(0, 7) == 0)
               sec = cont_byte();
            else if (lead == u8san_pkg::LEAD3_LO)
               sec = 8'($urandom_range(u8san_pkg::SEC3_MIN, 8'hBF));
            else if (lead == u8san_pkg::LEAD_SURR)
               sec = 8'($urandom_range(8'h80, u8san_pkg::SURR_MAX));
            else
               sec = cont_byte();
            add_data(lead);
            add_data(sec);
            add_data(cont_byte());
         end else if (pick < 74) begin
            lead = 8'($urandom_range(u8san_pkg::LEAD4_LO, u8san_pkg::LEAD4_HI));
            if ($urandom_range(0, 7) == 0)
               sec = cont_byte();
            else if (lead == u8san_pkg::LEAD4_LO)
               sec = 8'($urandom_range(u8san_pkg::SEC4_MIN, 8'hBF));
            else if (lead == u8san_pkg::LEAD4_HI)
               sec = 8'($urandom_range(8'h80, u8san_pkg::SEC4_MAX));
            else
               sec = cont_byte();
            add_data(lead);
            add_data(sec);
            add_data(cont_byte());
            add_data(cont_byte());
         end else if (pick < 84) begin
            // A lead with too few continuation bytes; whatever follows cuts it off.
            lead = 8'($urandom_range(u8san_pkg::LEAD2_LO, u8san_pkg::LEAD4_HI));
            add_data(lead);
            k = (lead >= u8san_pkg::LEAD4_LO) ? 2 : (lead >= u8san_pkg::LEAD3_LO) ? 1 : 0;
            k = $urandom_range(0, k);
            repeat (k) add_data(cont_byte());
         end else if (pick < 95) begin
            add_data(8'($urandom_range(0, 255)));
         end else begin
            add_end();
         end
      end
   endfunction

   task automatic send_item(logic kind, logic [7:0] b);
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, b);
   endtask

   // Called only after req_tvalid has been lowered in the current step.
   task automatic wait_drained();
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic run_plan(bit with_gaps, bit drain_mid);
      int unsigned i;
      int unsigned gap;
      for (i = 0; i < plan.size(); i++) begin
         if (drain_mid && i == plan.size() / 2) begin
            req_tvalid <= 1'b0;
            wait_drained();
         end else if (with_gaps && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         send_item(plan[i].kind, plan[i].data);
         if (burst_left != 0) burst_left--;
      end
      req_tvalid <= 1'b0;
      plan.delete();
      wait_drained();
      // Items that make no result may still be in flight inside the block.
      repeat (12) @(posedge clock);
   endtask

   task automatic write_limit(logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_limit(value);
      limit_writes++;
   endtask

   initial begin
      logic [31:0] lim;
      int unsigned ph;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_limit(32'hFFFF_FFFF);
      add_data(8'h00);
      add_data(8'h7F);
      add_data(8'h80);   // stray continuation
      add_data(8'hC0);   // never a valid lead
      add_data(8'hFF);
      add_data(8'hDF);
      add_data(8'hBF);
      add_data(8'hE0);   // overlong three-byte form
      add_data(8'h9F);
      add_data(8'h80);
      add_data(8'hED);   // surrogate
      add_data(8'hA0);
      add_data(8'h80);
      add_data(8'hF4);   // above the last code point
      add_data(8'h90);
      add_data(8'h80);
      add_data(8'h80);
      add_data(8'hF0);   // cut short by an ASCII byte, which is then kept
      add_data(8'h8F);
      add_data(8'h41);
      add_data(8'hE1);   // partial sequence flushed at the end of the stream
      add_end();
      add_end();
      run_plan(1'b0, 1'b0);

      // Zero limit: every unit is dropped and the stream ends truncated.
      write_limit(32'h0);
      add_data(8'h41);
      add_data(8'hC3);
      add_data(8'hA9);
      add_end();
      run_plan(1'b0, 1'b0);

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ((ph < 3) ? ph : $urandom_range(0, 5))
            0: lim = 32'($urandom_range(1, 8));
            1: lim = 32'($urandom_range(9, 40));
            2: lim = 32'hFFFF_FFFF;
            3: lim = 32'h0;
            4: lim = $urandom;
            default: lim = 32'($urandom_range(1, 3));
         endcase
         write_limit(lim);
         build_random_plan(PHASE_ITEMS);
         if ($urandom_range(0, 1) != 0) add_end();
         run_plan($urandom_range(0, 3) != 0, ph == 1 || $urandom_range(0, 2) == 0);
      end

      repeat (20) @(posedge clock);
      $display("Sent %0d request beats and checked %0d result beats under %0d limit writes.",
               sb.reqs_seen, sb.beats_checked, limit_writes);
      $display("Streams closed: %0d, of which %0d were cut at the limit.",
               sb.ends_seen, sb.cut_streams);
      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("utf8_sanitizer_core_test passed");
      else
         $display("utf8_sanitizer_core_test failed");
      $finish;
   end

endmodule
